FILE: rtl/qpe_pkg.sv
`timescale 1ns / 1ps

package qpe_pkg;

    // Line length limits for a plain character and for an escape.
    localparam logic [6:0] PLAIN_LIMIT  = 7'd75;
    localparam logic [6:0] ESCAPE_LIMIT = 7'd73;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // The job queue depth must be a power of two so the pointers wrap.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        K_NONE,
        K_PLAIN,
        K_ESC,
        K_CRLF
    } kind_t;

    // One classified input item: an optional soft break and part for the
    // held CR, then an optional soft break and part for the new byte.
    typedef struct packed {
        logic       sb_a;
        kind_t      kind_a;
        logic       sb_b;
        kind_t      kind_b;
        logic [7:0] data;
        logic       fin;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = 8'h37 + {4'd0, nib};
        end
        return r;
    endfunction

endpackage

FILE: rtl/qpe_front.sv
`timescale 1ns / 1ps

module qpe_front import qpe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       push,
    output job_t       job
);

    logic [6:0] line_length_reg, line_length_next;
    logic       cr_pending_reg, cr_pending_next;
    logic       space_before_cr_reg, space_before_cr_next;
    logic [7:0] previous_byte_reg;
    logic       seen_any_byte_reg;

    logic [6:0] ll_mid;
    logic       handled;
    logic       plain;

    always_comb begin
        plain = ((data_byte >= CH_SP) && (data_byte <= CH_LT))
             || ((data_byte >= CH_GT) && (data_byte <= CH_TILDE))
             || (data_byte == CH_TAB);

        job.data   = data_byte;
        job.fin    = final_byte;
        job.sb_a   = 1'b0;
        job.kind_a = K_NONE;
        job.sb_b   = 1'b0;
        job.kind_b = K_NONE;
        handled    = 1'b0;
        ll_mid     = line_length_reg;

        if (cr_pending_reg) begin
            if (data_byte == CH_LF) begin
                job.kind_a = K_CRLF;
                job.sb_a   = space_before_cr_reg;
                ll_mid     = 7'd0;
                handled    = 1'b1;
            end else begin
                job.kind_a = K_ESC;
                job.sb_a   = (line_length_reg >= ESCAPE_LIMIT);
                ll_mid     = job.sb_a ? 7'd3 : line_length_reg + 7'd3;
            end
        end

        line_length_next     = ll_mid;
        cr_pending_next      = 1'b0;
        space_before_cr_next = 1'b0;
        if (!handled) begin
            if ((data_byte == CH_CR) && !final_byte) begin
                // Hold the CR until the next byte shows whether an LF follows.
                cr_pending_next      = 1'b1;
                space_before_cr_next = seen_any_byte_reg
                    && ((previous_byte_reg == CH_TAB) || (previous_byte_reg == CH_SP));
            end else if (plain) begin
                job.kind_b       = K_PLAIN;
                job.sb_b         = (ll_mid == PLAIN_LIMIT);
                line_length_next = job.sb_b ? 7'd1 : ll_mid + 7'd1;
            end else begin
                job.kind_b       = K_ESC;
                job.sb_b         = (ll_mid >= ESCAPE_LIMIT);
                line_length_next = job.sb_b ? 7'd3 : ll_mid + 7'd3;
            end
        end

        push = accept && ((job.kind_a != K_NONE) || (job.kind_b != K_NONE));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg     <= 7'd0;
            cr_pending_reg      <= 1'b0;
            space_before_cr_reg <= 1'b0;
            previous_byte_reg   <= 8'd0;
            seen_any_byte_reg   <= 1'b0;
        end else if (accept) begin
            if (final_byte) begin
                line_length_reg     <= 7'd0;
                cr_pending_reg      <= 1'b0;
                space_before_cr_reg <= 1'b0;
                previous_byte_reg   <= 8'd0;
                seen_any_byte_reg   <= 1'b0;
            end else begin
                line_length_reg     <= line_length_next;
                cr_pending_reg      <= cr_pending_next;
                space_before_cr_reg <= space_before_cr_next;
                previous_byte_reg   <= data_byte;
                seen_any_byte_reg   <= 1'b1;
            end
        end
    end

endmodule

FILE: rtl/qpe_fifo.sv
`timescale 1ns / 1ps

module qpe_fifo import qpe_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_en,
    input  job_t         wr_data,
    input  logic         rd_en,
    output job_t         rd_data,
    output fifo_status_t status
);

    job_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    logic do_wr, do_rd;

    assign status.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr   = wr_en && !status.full;
    assign do_rd   = rd_en && !status.empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/qpe_back.sv
`timescale 1ns / 1ps

module qpe_back import qpe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       job_avail,
    input  job_t       job_in,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tuser,
    output logic       m_tlast
);

    typedef enum logic [1:0] {
        P_SBA,
        P_A,
        P_SBB,
        P_B
    } phase_t;

    typedef struct packed {
        logic   found;
        phase_t phase;
    } search_t;

    function automatic logic [1:0] kind_len(input kind_t k);
        logic [1:0] r;
        unique case (k)
            K_NONE:  r = 2'd0;
            K_PLAIN: r = 2'd1;
            K_ESC:   r = 2'd3;
            K_CRLF:  r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] part_len(input job_t j, input phase_t p);
        logic [1:0] r;
        unique case (p)
            P_SBA:   r = j.sb_a ? 2'd3 : 2'd0;
            P_A:     r = kind_len(j.kind_a);
            P_SBB:   r = j.sb_b ? 2'd3 : 2'd0;
            P_B:     r = kind_len(j.kind_b);
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // First phase at or after start that has characters to send.
    function automatic search_t find_phase(input job_t j, input logic [2:0] start);
        search_t r;
        r.found = 1'b0;
        r.phase = P_SBA;
        for (int i = 3; i >= 0; i--) begin
            if ((3'(i) >= start) && (part_len(j, phase_t'(i[1:0])) != 2'd0)) begin
                r.found = 1'b1;
                r.phase = phase_t'(i[1:0]);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] part_char(input kind_t k, input logic [7:0] b,
                                             input logic [1:0] idx);
        logic [7:0] r;
        unique case (k)
            K_PLAIN: r = b;
            K_CRLF:  r = (idx == 2'd0) ? CH_CR : CH_LF;
            K_ESC: begin
                if (idx == 2'd0) begin
                    r = CH_EQ;
                end else if (idx == 2'd1) begin
                    r = hex_char(b[7:4]);
                end else begin
                    r = hex_char(b[3:0]);
                end
            end
            default: r = CH_EQ;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] break_char(input logic [1:0] idx);
        logic [7:0] r;
        if (idx == 2'd0) begin
            r = CH_EQ;
        end else if (idx == 2'd1) begin
            r = CH_CR;
        end else begin
            r = CH_LF;
        end
        return r;
    endfunction

    job_t       job_reg;
    logic       job_valid_reg;
    phase_t     phase_reg;
    logic [1:0] idx_reg;

    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_user_reg;
    logic       m_last_reg;

    logic [7:0] cur_char;
    logic       idx_end;
    logic       char_last;
    logic       out_free;
    logic       load_char;
    search_t    nxt;
    search_t    first;

    always_comb begin
        unique case (phase_reg)
            P_SBA:   cur_char = break_char(idx_reg);
            P_A:     cur_char = part_char(job_reg.kind_a, CH_CR, idx_reg);
            P_SBB:   cur_char = break_char(idx_reg);
            P_B:     cur_char = part_char(job_reg.kind_b, job_reg.data, idx_reg);
            default: cur_char = CH_EQ;
        endcase
        idx_end   = (idx_reg == part_len(job_reg, phase_reg) - 2'd1);
        nxt       = find_phase(job_reg, {1'b0, phase_reg} + 3'd1);
        first     = find_phase(job_in, 3'd0);
        char_last = idx_end && !nxt.found;
        out_free  = !m_valid_reg || m_tready;
        load_char = job_valid_reg && out_free;
        // Fetch the next job while the last character of this one goes out.
        pop       = job_avail && (!job_valid_reg || (load_char && char_last));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                job_valid_reg <= 1'b1;
            end else if (load_char && char_last) begin
                job_valid_reg <= 1'b0;
            end
            if (load_char) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg   <= job_in;
            phase_reg <= first.phase;
            idx_reg   <= 2'd0;
        end else if (load_char && !char_last) begin
            if (idx_end) begin
                phase_reg <= nxt.phase;
                idx_reg   <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
        if (load_char) begin
            m_data_reg <= cur_char;
            m_user_reg <= char_last;
            m_last_reg <= char_last && job_reg.fin;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/quoted_printable_encoder.sv
`timescale 1ns / 1ps
// An accepted item passes through the job queue and the job register before its first character
// reaches the output register on m_tdata. Throughput: one character per cycle from the output register
// while m_tready is high; an item makes 1 character for a plain byte, 3 for an escape, up to 9, none for a held CR.
// A 4-entry job queue lets input run ahead of output.
// Reset: synchronous, active low; clears line state, pending CR, the job queue and m_tvalid.

module quoted_printable_encoder import qpe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tuser,   // [0] run_end
    output logic       m_tlast
);

    logic         accept;
    logic         push;
    logic         pop;
    job_t         job_wr;
    job_t         job_rd;
    fifo_status_t fifo_st;

    assign s_tready = !fifo_st.full;
    assign accept   = s_tvalid && s_tready;

    qpe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .push       (push),
        .job        (job_wr)
    );

    qpe_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (job_wr),
        .rd_en   (pop),
        .rd_data (job_rd),
        .status  (fifo_st)
    );

    qpe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_avail (!fifo_st.empty),
        .job_in    (job_rd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: rtl/qpe_checker.sv
`timescale 1ns / 1ps

module qpe_checker import qpe_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result changed while stalled");

    // The end of a message is always the end of an item's run.
    a_msg_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("message end without run end");

    // An item never ends on '=': escapes and soft breaks are always complete.
    a_no_dangling_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata != CH_EQ))
        else $error("item ended on an escape character");

    // Nothing is presented on the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A CR in the output is always followed by its LF, so a run end never falls on a CR.
    a_cr_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata != CH_CR))
        else $error("item ended on a bare CR");

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: tb/sv/qp_char_checker.sv
`timescale 1ns / 1ps

module qp_char_checker import qpe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_char
    input  logic       m_tuser,   // [0] run_end
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending_count
);

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       msg_end;
    } qp_char_t;

    qp_char_t   expected_chars[$];
    logic [7:0] item_chars[$];

    // Mirror of the encoder's line state.
    logic [6:0] line_len;
    logic       cr_held;
    logic       ws_before_cr;
    logic [7:0] last_byte;
    logic       seen_byte;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? ("0" + nib) : ("A" + nib - 4'd10);
    endfunction

    task automatic clear_line_state();
        line_len     = 7'd0;
        cr_held      = 1'b0;
        ws_before_cr = 1'b0;
        last_byte    = 8'h00;
        seen_byte    = 1'b0;
    endtask

    task automatic soft_break_chars();
        item_chars.push_back(CH_EQ);
        item_chars.push_back(CH_CR);
        item_chars.push_back(CH_LF);
    endtask

    task automatic encode_char(input logic [7:0] c);
        logic plain;
        plain = (c == CH_TAB) || (c >= CH_SP && c <= CH_TILDE && c != CH_EQ);
        if (plain) begin
            if (line_len == PLAIN_LIMIT) begin
                soft_break_chars();
                line_len = 7'd1;
            end else begin
                line_len = line_len + 7'd1;
            end
            item_chars.push_back(c);
        end else begin
            if (line_len >= ESCAPE_LIMIT) begin
                soft_break_chars();
                line_len = 7'd3;
            end else begin
                line_len = line_len + 7'd3;
            end
            item_chars.push_back(CH_EQ);
            item_chars.push_back(hex_digit(c[7:4]));
            item_chars.push_back(hex_digit(c[3:0]));
        end
    endtask

    // Works out the characters one accepted byte causes and queues them.
    task automatic encode_item(input logic [7:0] data, input logic fin);
        logic     hard_break;
        qp_char_t exp_char;
        int       n;
        hard_break = 1'b0;
        item_chars.delete();
        if (cr_held) begin
            cr_held = 1'b0;
            if (data == CH_LF) begin
                if (ws_before_cr) begin
                    soft_break_chars();
                end
                item_chars.push_back(CH_CR);
                item_chars.push_back(CH_LF);
                line_len   = 7'd0;
                hard_break = 1'b1;
            end else begin
                encode_char(CH_CR);
            end
            ws_before_cr = 1'b0;
        end
        if (!hard_break) begin
            if (data == CH_CR && !fin) begin
                cr_held      = 1'b1;
                ws_before_cr = seen_byte && (last_byte == CH_TAB || last_byte == CH_SP);
            end else begin
                encode_char(data);
            end
        end
        last_byte = data;
        seen_byte = 1'b1;
        n = item_chars.size();
        for (int i = 0; i < n; i++) begin
            exp_char.ch      = item_chars[i];
            exp_char.run_end = (i == n - 1);
            exp_char.msg_end = (i == n - 1) && fin;
            expected_chars.push_back(exp_char);
        end
        if (fin) begin
            clear_line_state();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        // Keep the log readable when a broken build fails on every character.
        if (fail_count < 40) begin
            $display("[%0t] qp mismatch: %s got %h expected %h", $time, what, got, want);
        end
        fail_count++;
    endtask

    always @(posedge aclk) begin
        qp_char_t want;
        if (!aresetn) begin
            clear_line_state();
            expected_chars.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                encode_item(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("character with none expected", m_tdata, 8'h00);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.ch) begin
                        report_mismatch("out_char", m_tdata, want.ch);
                    end
                    if (m_tuser !== want.run_end) begin
                        report_mismatch("run_end", {7'd0, m_tuser}, {7'd0, want.run_end});
                    end
                    if (m_tlast !== want.msg_end) begin
                        report_mismatch("message_end", {7'd0, m_tlast}, {7'd0, want.msg_end});
                    end
                end
            end
        end
        pending_count = expected_chars.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import qpe_pkg::*;

    localparam int ITEM_TARGET = 270;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    int fail_count;
    int pending_count;
    int sender_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int cycle_count;

    quoted_printable_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    qp_char_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever hold_cycles is set.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // s_tready only changes at a rising edge, so its value at the falling edge
    // tells whether the item is taken at the next rising edge.
    task automatic send_item(input logic [7:0] data, input logic fin);
        logic ready_now;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= fin;
        ready_now = s_tready;
        @(negedge aclk);
        while (!ready_now) begin
            ready_now = s_tready;
            @(negedge aclk);
        end
    endtask

    initial begin
        int         items_sent;
        int         msg_len;
        int         pick;
        int         phase;
        logic       lf_next;
        logic       pressure_done;
        logic [7:0] b;

        items_sent      = 0;
        lf_next         = 1'b0;
        pressure_done   = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_cycles     = 0;
        s_tvalid        = 1'b0;
        s_tdata         = 8'h00;
        s_tlast         = 1'b0;
        aresetn         = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Byte extremes, the escaped specials and the plain edge cases, then space before a CR LF pair.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_EQ, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(CH_TILDE, 1'b0);
        send_item(CH_TAB, 1'b0);
        send_item(CH_SP, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        // A lone CR before a plain byte, then two CRs in a row ending in a line break.
        send_item(CH_CR, 1'b0);
        send_item("x", 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        // A tab before a CR that turns out to be lone, then trailing whitespace.
        send_item(CH_TAB, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(CH_SP, 1'b1);
        // A final CR on its own, a held CR closed by a final LF, a held CR before a final CR.
        send_item(CH_CR, 1'b1);
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b1);
        send_item("a", 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_CR, 1'b1);
        items_sent = 24;

        // Random messages: mostly long text lines so the line limits are reached.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(99) < 70) begin
                msg_len = $urandom_range(160, 60);
            end else begin
                msg_len = $urandom_range(12, 1);
            end
            if (msg_len > ITEM_TARGET - items_sent) begin
                msg_len = ITEM_TARGET - items_sent;
            end
            lf_next = 1'b0;
            for (int i = 0; i < msg_len; i++) begin
                phase = (items_sent / 40) % 4;
                case (phase)
                    0: begin
                        sender_idle_pct = 0;
                        recv_stall_pct  = 0;
                    end
                    1: begin
                        sender_idle_pct = 45;
                        recv_stall_pct  = 0;
                    end
                    2: begin
                        sender_idle_pct = 0;
                        recv_stall_pct  = 45;
                    end
                    default: begin
                        sender_idle_pct = 10;
                        recv_stall_pct  = 10;
                    end
                endcase
                // Hold the output back long enough for the job queue to fill up.
                if (!pressure_done && phase == 0 && items_sent >= 165) begin
                    hold_cycles   = 300;
                    pressure_done = 1'b1;
                end
                if (lf_next) begin
                    b       = CH_LF;
                    lf_next = 1'b0;
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 55) begin
                        b = 8'($urandom_range(126, 32));
                    end else if (pick < 63) begin
                        b = ($urandom_range(1) == 0) ? CH_SP : CH_TAB;
                    end else if (pick < 67) begin
                        b       = CH_CR;
                        lf_next = 1'b1;
                    end else if (pick < 70) begin
                        b = CH_CR;
                    end else if (pick < 74) begin
                        b = CH_EQ;
                    end else begin
                        b = 8'($urandom_range(255));
                    end
                end
                send_item(b, (i == msg_len - 1));
                items_sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
